// ===== design/ipbl_pkg.sv =====
// shared types and codes for the ip range blocklist match unit
// no dependencies
package ipbl_pkg;

    localparam int MAX_ENTRIES_DEF = 128;
    localparam int ADDR_W          = 128;
    localparam int HALF_W          = 64;
    localparam int V4_W            = 32;

    localparam logic       CMD_ADD   = 1'b0;
    localparam logic       CMD_CHECK = 1'b1;

    localparam logic [1:0] FAM_V4    = 2'd0;
    localparam logic [1:0] FAM_V6    = 2'd1;

    typedef struct packed {
        logic              fam_v6;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
    } entry_t;

endpackage

// ===== design/ip_range_blocklist_match_unit.sv =====
// ip range blocklist match unit: range table in a single-port memory, scanned by one comparator
// depends on ipbl_pkg
//
// Stores up to MAX_ENTRIES inclusive address ranges, each tagged IPv4 or IPv6, and answers
// one word per command on the out channel. An add writes the next free table entry in the
// accept cycle and its result goes through the done state to the output register; status is 1
// when the table was full. A check of an IPv4 or IPv6 address reads the table one entry per
// cycle through a registered memory port and tests it with one 128-bit range comparator, so
// with N stored ranges it reads at most N, stopping early on a hit. Local and unknown families never
// match and are answered with status 0. A finished result waits in the output register, and the
// next word is taken while it waits; a new word is not taken while a command is in progress.
module ip_range_blocklist_match_unit
    import ipbl_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [1:0]          family,
    input  logic [HALF_W-1:0]   addr_hi,
    input  logic [HALF_W-1:0]   addr_lo,
    input  logic [HALF_W-1:0]   start_hi,
    input  logic [HALF_W-1:0]   start_lo,
    input  logic [HALF_W-1:0]   stop_hi,
    input  logic [HALF_W-1:0]   stop_lo,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                matched,
    output logic                status
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic              hit_reg, hit_next;
    logic              res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic              matched_reg, matched_next;
    logic              status_reg, status_next;

    logic              key_v6_reg;
    logic [ADDR_W-1:0] key_reg;

    entry_t            range_mem_reg [MAX_ENTRIES];
    entry_t            rd_data_reg;
    entry_t            wr_entry;

    logic              accept;
    logic              fam_ok;
    logic              full;
    logic              do_write;
    logic              do_read;
    logic              in_range;
    logic [ADDR_W-1:0] key_in;

    assign accept   = in_valid && in_ready;
    assign fam_ok   = (family == FAM_V4) || (family == FAM_V6);
    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign do_write = accept && (command == CMD_ADD) && fam_ok && !full;
    assign do_read  = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg) && !hit_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign status    = status_reg;

    always_comb
    begin
        if (family == FAM_V4)
        begin
            wr_entry.fam_v6 = 1'b0;
            wr_entry.start  = {{(ADDR_W - V4_W){1'b0}}, start_lo[V4_W-1:0]};
            wr_entry.stop   = {{(ADDR_W - V4_W){1'b0}}, stop_lo[V4_W-1:0]};
            key_in          = {{(ADDR_W - V4_W){1'b0}}, addr_lo[V4_W-1:0]};
        end
        else
        begin
            wr_entry.fam_v6 = 1'b1;
            wr_entry.start  = {start_hi, start_lo};
            wr_entry.stop   = {stop_hi, stop_lo};
            key_in          = {addr_hi, addr_lo};
        end
    end

    // the one shared range comparator
    assign in_range = (rd_data_reg.fam_v6 == key_v6_reg)
                   && (rd_data_reg.start <= key_reg)
                   && (key_reg <= rd_data_reg.stop);

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            range_mem_reg[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (do_read)
        begin
            rd_data_reg <= range_mem_reg[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg    <= key_in;
            key_v6_reg <= (family == FAM_V6);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        pipe_vld_next   = 1'b0;
        hit_next        = hit_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        matched_next    = matched_reg;
        status_next     = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next        = 1'b0;
                    scan_idx_next   = '0;
                    res_status_next = 1'b0;
                    if (command == CMD_ADD)
                    begin
                        if (fam_ok && full)
                        begin
                            res_status_next = 1'b1;
                        end
                        if (do_write)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = ST_DONE;
                    end
                    else if (fam_ok)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pipe_vld_reg && in_range)
                begin
                    hit_next = 1'b1;
                end
                if (do_read)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    pipe_vld_next = 1'b1;
                end
                else if (!pipe_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    matched_next   = hit_reg;
                    status_next    = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            res_status_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            matched_reg    <= 1'b0;
            status_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            pipe_vld_reg   <= pipe_vld_next;
            hit_reg        <= hit_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            matched_reg    <= matched_next;
            status_reg     <= status_next;
        end
    end

endmodule

// ===== design/ipbl_checker.sv =====
// port-level checks for the ip range blocklist match unit, bound to the top level
// depends on ip_range_blocklist_match_unit
module ipbl_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                matched,
    input logic                status
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(status))
        else $error("result word changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in progress");

    // a match only comes from a check, a refusal only from an add, so both are never set together
    a_match_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(matched && status))
        else $error("matched and status both set");

    // a new result is only loaded after the command finished
    a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a finished command");

endmodule

bind ip_range_blocklist_match_unit ipbl_checker u_ipbl_checker (.*);
